[rtl/nfa_pkg.sv]
package nfa_pkg;

  // Widths of the command and result fields.
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned BLOCK_IDX_W = 4;
  localparam int unsigned PAGE_IDX_W  = 4;
  localparam int unsigned COLUMN_W    = 8;
  localparam int unsigned DATA_W      = 8;

  // Highest counts that the index fields can reach.
  localparam int unsigned BLOCK_REACH  = 1 << BLOCK_IDX_W;
  localparam int unsigned PAGE_REACH   = 1 << PAGE_IDX_W;
  localparam int unsigned COLUMN_REACH = 1 << COLUMN_W;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_READ     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PROGRAM  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ERASE    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_MARK_BAD = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd4;

  // Value of every byte after an erase.
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

endpackage

[rtl/nand_flash_array_model.sv]
// A result passes through the second stage and the output register after its command beat.
// Throughput: one byte read, program, mark or query per cycle while the output is
// free and no erase runs; program is a read, modify and write of the cell memory
// with forwarding between neighbouring beats. An erase stalls input while it
// walks the block, one byte a cycle. Reset clears all bad marks and the handshake
// state; cell data stays undefined until its block is erased.
module nand_flash_array_model #(
  parameter int unsigned NUM_BLOCKS      = 16,
  parameter int unsigned PAGES_PER_BLOCK = 16,
  parameter int unsigned PAGE_BYTES      = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nfa_pkg::ACTION_W-1:0]    action_i,
  input  logic [nfa_pkg::BLOCK_IDX_W-1:0] block_index_i,
  input  logic [nfa_pkg::PAGE_IDX_W-1:0]  page_index_i,
  input  logic [nfa_pkg::COLUMN_W-1:0]    column_i,
  input  logic [nfa_pkg::DATA_W-1:0]      write_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nfa_pkg::DATA_W-1:0]      read_data_o,
  output logic                            block_bad_o
);
  import nfa_pkg::*;

  // Only blocks, pages and columns that the index fields can reach get storage.
  localparam int unsigned NB = (NUM_BLOCKS < BLOCK_REACH) ? NUM_BLOCKS : BLOCK_REACH;
  localparam int unsigned NP = (PAGES_PER_BLOCK < PAGE_REACH) ? PAGES_PER_BLOCK : PAGE_REACH;
  localparam int unsigned NC = (PAGE_BYTES < COLUMN_REACH) ? PAGE_BYTES : COLUMN_REACH;
  localparam int unsigned BLK_BYTES = NP * NC;
  localparam int unsigned MEM_DEPTH = NB * BLK_BYTES;
  localparam int unsigned AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned BIW = (NB > 1) ? $clog2(NB) : 1;

  // Handshake and decode.
  logic          in_acc, s1_adv;
  logic          blk_ok, cell_ok;
  logic [31:0]   lin_addr, base_lin;
  logic [AW-1:0] addr, base_addr;
  logic [BIW-1:0] blk_sel;
  logic          bad_cur, bad_res;

  // Bad marks, one flip-flop per reachable block.
  logic [NB-1:0] bad_q, bad_d;

  // Second stage: the beat whose memory read is in flight.
  logic              s1_valid_q, s1_valid_d;
  logic              s1_is_read_q, s1_is_prog_q;
  logic [AW-1:0]     s1_addr_q;
  logic [DATA_W-1:0] s1_wdata_q;
  logic              s1_bad_q;
  logic              fwd_q;
  logic [DATA_W-1:0] fwd_data_q;
  logic [DATA_W-1:0] cur_data, s1_wval;
  logic              s1_wr;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic              out_bad_q;

  // Memory ports and erase walker.
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic [DATA_W-1:0] mem_rd_data;
  logic              erase_busy, erase_start;
  logic [AW-1:0]     erase_addr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = erase_busy || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Address decode of the command beat.
  always_comb begin
    blk_ok    = 32'(block_index_i) < NB;
    cell_ok   = (32'(page_index_i) < NP) && (32'(column_i) < NC);
    base_lin  = 32'(block_index_i) * 32'(BLK_BYTES);
    lin_addr  = base_lin + 32'(page_index_i) * 32'(NC) + 32'(column_i);
    addr      = lin_addr[AW-1:0];
    base_addr = base_lin[AW-1:0];
    blk_sel   = BIW'(block_index_i);
    bad_cur   = blk_ok && bad_q[blk_sel];
  end

  // The reported mark is the one left after this beat's action.
  always_comb begin
    bad_res = 1'b0;
    bad_d   = bad_q;
    if (blk_ok) begin
      case (action_i)
        ACT_ERASE: begin
          bad_res = 1'b0;
          if (in_acc) bad_d[blk_sel] = 1'b0;
        end
        ACT_MARK_BAD: begin
          bad_res = 1'b1;
          if (in_acc) bad_d[blk_sel] = 1'b1;
        end
        default: bad_res = bad_cur;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= '0;
    end else begin
      bad_q <= bad_d;
    end
  end

  // Read, modify and write back; a program of the previous beat is forwarded.
  assign cur_data = fwd_q ? fwd_data_q : mem_rd_data;
  assign s1_wval  = cur_data & s1_wdata_q;
  assign s1_wr    = s1_adv && s1_is_prog_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_is_read_q <= blk_ok && cell_ok && (action_i == ACT_READ);
      s1_is_prog_q <= blk_ok && cell_ok && (action_i == ACT_PROGRAM);
      s1_addr_q    <= addr;
      s1_wdata_q   <= write_data_i;
      s1_bad_q     <= bad_res;
      fwd_q        <= s1_wr && (s1_addr_q == addr);
      fwd_data_q   <= s1_wval;
    end
  end

  // Output register, free again once its beat is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= s1_is_read_q ? cur_data : '0;
      out_bad_q  <= s1_bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign block_bad_o = out_bad_q;

  // Erase walker and the single write port of the cell memory.
  assign erase_start = in_acc && blk_ok && (action_i == ACT_ERASE);

  nfa_erase_seq #(
    .AW        (AW),
    .BLK_BYTES (BLK_BYTES)
  ) u_erase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (erase_start),
    .base_i  (base_addr),
    .busy_o  (erase_busy),
    .addr_o  (erase_addr)
  );

  assign mem_wr_en   = erase_busy || s1_wr;
  assign mem_wr_addr = erase_busy ? erase_addr : s1_addr_q;
  assign mem_wr_data = erase_busy ? ERASED_BYTE : s1_wval;

  nfa_cell_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (in_acc),
    .rd_addr_i (addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

[rtl/nfa_cell_mem.sv]
module nfa_cell_mem #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [nfa_pkg::DATA_W-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [nfa_pkg::DATA_W-1:0] rd_data_o
);
  import nfa_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with registered data; the data holds between reads.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/nfa_erase_seq.sv]
module nfa_erase_seq #(
  parameter int unsigned AW        = 16,
  parameter int unsigned BLK_BYTES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] base_i,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);
  import nfa_pkg::*;

  localparam int unsigned EW = (BLK_BYTES > 1) ? $clog2(BLK_BYTES) : 1;
  localparam logic [EW-1:0] LAST = EW'(BLK_BYTES - 1);

  logic          busy_q, busy_d;
  logic [EW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] base_q;

  // Walk the block one byte a cycle from its first byte to its last.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // The base address is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      base_q <= base_i;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = base_q + AW'(cnt_q);

endmodule

[rtl/nfa_checker.sv]
module nfa_checker #(
  parameter int unsigned NUM_BLOCKS = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [nfa_pkg::ACTION_W-1:0]    action_i,
  input logic [nfa_pkg::BLOCK_IDX_W-1:0] block_index_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [nfa_pkg::DATA_W-1:0]      read_data_o,
  input logic                            block_bad_o
);
  import nfa_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o)
      && $stable(block_bad_o))
    else $error("result beat changed while stalled");

  // An accepted erase of an existing block starts the walk and holds off input.
  a_erase_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_ERASE)
      && (32'(block_index_i) < NUM_BLOCKS) |=> in_stall_o)
    else $error("erase did not stall input");

  // An accepted command beat yields a result once the output drains while it waits in the second stage.
  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result beat missing");

endmodule

bind nand_flash_array_model nfa_checker #(
  .NUM_BLOCKS (NUM_BLOCKS)
) u_nfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .block_index_i (block_index_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_data_o   (read_data_o),
  .block_bad_o   (block_bad_o)
);
